// ===== hdl/left_neighbour_slope_filter_core_assert.svh =====
// Assertion macros shared by the slope filter RTL.
// No dependencies; include with the bare file name.
`ifndef LEFT_NEIGHBOUR_SLOPE_FILTER_CORE_ASSERT_SVH
`define LEFT_NEIGHBOUR_SLOPE_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define LSF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slope filter: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define LSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slope filter: next-cycle check failed");

`endif

// ===== hdl/lsf_pkg.sv =====
// Shared widths, codes, control struct and arctangent table of the slope filter.
// No dependencies.
package lsf_pkg;

  localparam int DATA_W       = 32;
  localparam int DIFF_W       = 33;
  localparam int PROD_W       = 64;
  localparam int CORDIC_W     = 43;
  localparam int ANGLE_W      = 25;
  localparam int ATAN_W       = 22;
  localparam int CORDIC_STEPS = 23;
  localparam int STEP_W       = 5;
  localparam int PRESCALE_TOP = 40;

  localparam logic [15:0] ANGLE_Q8_MAX = 16'd23040;

  localparam logic [1:0] METHOD_DIFF    = 2'd0;
  localparam logic [1:0] METHOD_PERCENT = 2'd1;
  localparam logic [1:0] METHOD_ANGLE   = 2'd2;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_METHOD   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_CELL = 1'b1;

  localparam logic [DATA_W-1:0] INV_CELL_RESET = 32'd16777216;

  // Per-item control that rides along the pipeline.
  typedef struct packed {
    logic valid;      // stage holds an item
    logic pair;       // item closes a pending cell: one paired result
    logic ok;         // paired result carries data
    logic row_end;    // item ends a row: one trailing no-data result
    logic neg;        // difference was negative
    logic use_angle;  // value comes from the angle path
    logic zero_p;     // scaled ratio was zero
  } lsf_ctl_t;

  // atan(2^-i) in degrees, 16 fraction bits.
  function automatic logic [ATAN_W-1:0] atan_deg_q16(input logic [STEP_W-1:0] step);
    logic [ATAN_W-1:0] a;
    case (step)
      5'd0:    a = 22'd2949120;
      5'd1:    a = 22'd1740967;
      5'd2:    a = 22'd919879;
      5'd3:    a = 22'd466945;
      5'd4:    a = 22'd234379;
      5'd5:    a = 22'd117304;
      5'd6:    a = 22'd58666;
      5'd7:    a = 22'd29335;
      5'd8:    a = 22'd14668;
      5'd9:    a = 22'd7334;
      5'd10:   a = 22'd3667;
      5'd11:   a = 22'd1833;
      5'd12:   a = 22'd917;
      5'd13:   a = 22'd458;
      5'd14:   a = 22'd229;
      5'd15:   a = 22'd115;
      5'd16:   a = 22'd57;
      5'd17:   a = 22'd29;
      5'd18:   a = 22'd14;
      5'd19:   a = 22'd7;
      5'd20:   a = 22'd4;
      5'd21:   a = 22'd2;
      5'd22:   a = 22'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/lsf_front.sv =====
// Front end of the slope filter: difference, scaling product, percent slope
// and CORDIC prescale over three stages. Depends on lsf_pkg.
module lsf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  lsf_pkg::lsf_ctl_t                   in_ctl,
  input  logic signed [lsf_pkg::DATA_W-1:0]   in_a,
  input  logic signed [lsf_pkg::DATA_W-1:0]   in_b,
  input  logic [1:0]                          method,
  input  logic [lsf_pkg::DATA_W-1:0]          inv_cell_size,
  output lsf_pkg::lsf_ctl_t                   out_ctl,
  output logic [lsf_pkg::DATA_W-1:0]          out_val,
  output logic signed [lsf_pkg::CORDIC_W-1:0] out_x,
  output logic signed [lsf_pkg::CORDIC_W-1:0] out_y
);
  import lsf_pkg::*;

  // stage 1: difference
  lsf_ctl_t                  s1_ctl;
  logic signed [DIFF_W-1:0]  s1_d;
  logic [1:0]                s1_method;
  logic [DATA_W-1:0]         s1_ics;

  // stage 2: product
  lsf_ctl_t                  s2_ctl;
  lsf_ctl_t                  s2_ctl_next;
  logic [PROD_W-1:0]         s2_p;
  logic [PROD_W-1:0]         s2_p_next;
  logic [DATA_W-1:0]         s2_sat;
  logic [DATA_W-1:0]         s2_sat_next;
  logic [1:0]                s2_method;

  // stage 3 combinational values
  lsf_ctl_t                  s3_ctl_next;
  logic [DATA_W-1:0]         s3_val_next;
  logic signed [CORDIC_W-1:0] s3_x_next;
  logic signed [CORDIC_W-1:0] s3_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl <= in_ctl;
    end
    if (adv) begin
      s1_d      <= DIFF_W'(in_a) - DIFF_W'(in_b);
      s1_method <= method;
      s1_ics    <= inv_cell_size;
    end
  end

  always_comb begin
    logic [DIFF_W-1:0] mag;
    logic              neg;
    neg = s1_d[DIFF_W-1];
    mag = neg ? DIFF_W'(-s1_d) : DIFF_W'(s1_d);
    // magnitude of 2^32 is the only case with the top bit set
    if (mag[DIFF_W-1]) begin
      s2_p_next = {s1_ics, 32'd0};
    end else begin
      s2_p_next = mag[DATA_W-1:0] * s1_ics;
    end
    if (s1_d[DIFF_W-1] != s1_d[DIFF_W-2]) begin
      s2_sat_next = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      s2_sat_next = s1_d[DATA_W-1:0];
    end
    s2_ctl_next           = s1_ctl;
    s2_ctl_next.neg       = neg;
    s2_ctl_next.use_angle = s1_ctl.ok && (s1_method == METHOD_ANGLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (adv) begin
      s2_ctl <= s2_ctl_next;
    end
    if (adv) begin
      s2_p      <= s2_p_next;
      s2_sat    <= s2_sat_next;
      s2_method <= s1_method;
    end
  end

  always_comb begin
    logic [39:0]       hi;
    logic [23:0]       lo;
    logic [46:0]       hi100;
    logic [30:0]       t;
    logic [46:0]       q;
    logic [DATA_W-1:0] m1;
    logic [DATA_W-1:0] val1;
    logic [STEP_W-1:0] sh;
    logic [PROD_W-1:0] y_sh;
    logic [32:0]       x_sh;
    hi    = s2_p[63:24];
    lo    = s2_p[23:0];
    hi100 = {hi, 6'd0} + {1'b0, hi, 5'd0} + {5'd0, hi, 2'd0};
    t     = {1'b0, lo, 6'd0} + {2'b0, lo, 5'd0} + {5'd0, lo, 2'd0} + 31'h0080_0000;
    q     = hi100 + 47'(t[30:24]);
    m1    = (q[46:31] != '0) ? 32'h8000_0000 : q[31:0];
    if (s2_ctl.neg) begin
      val1 = ~m1 + 32'd1;
    end else begin
      val1 = m1[31] ? 32'h7fff_ffff : m1;
    end
    case (s2_method)
      METHOD_DIFF:    s3_val_next = s2_sat;
      METHOD_PERCENT: s3_val_next = val1;
      default:        s3_val_next = '0;
    endcase

    // halve both operands until the ratio fits below 2^40
    sh = '0;
    for (int i = 0; i < PROD_W - PRESCALE_TOP; i++) begin
      if (s2_p[PRESCALE_TOP + i]) sh = STEP_W'(i + 1);
    end
    y_sh      = s2_p >> sh;
    x_sh      = 33'h1_0000_0000 >> sh;
    s3_x_next = $signed({10'd0, x_sh});
    s3_y_next = $signed({3'd0, y_sh[PRESCALE_TOP-1:0]});

    s3_ctl_next        = s2_ctl;
    s3_ctl_next.zero_p = (s2_p == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (adv) begin
      out_ctl <= s3_ctl_next;
    end
    if (adv) begin
      out_val <= s3_val_next;
      out_x   <= s3_x_next;
      out_y   <= s3_y_next;
    end
  end

endmodule

// ===== hdl/lsf_cordic_stage.sv =====
// One vectoring CORDIC iteration with its pipeline register.
// Depends on lsf_pkg for widths, control struct and the arctangent table.
module lsf_cordic_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic [lsf_pkg::STEP_W-1:0]          step,
  input  lsf_pkg::lsf_ctl_t                   in_ctl,
  input  logic [lsf_pkg::DATA_W-1:0]          in_val,
  input  logic signed [lsf_pkg::CORDIC_W-1:0] in_x,
  input  logic signed [lsf_pkg::CORDIC_W-1:0] in_y,
  input  logic signed [lsf_pkg::ANGLE_W-1:0]  in_z,
  output lsf_pkg::lsf_ctl_t                   out_ctl,
  output logic [lsf_pkg::DATA_W-1:0]          out_val,
  output logic signed [lsf_pkg::CORDIC_W-1:0] out_x,
  output logic signed [lsf_pkg::CORDIC_W-1:0] out_y,
  output logic signed [lsf_pkg::ANGLE_W-1:0]  out_z
);
  import lsf_pkg::*;

  logic signed [CORDIC_W-1:0] x_next;
  logic signed [CORDIC_W-1:0] y_next;
  logic signed [ANGLE_W-1:0]  z_next;

  always_comb begin
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [ANGLE_W-1:0]  a;
    xs = in_x >>> step;
    ys = in_y >>> step;
    a  = $signed({3'd0, atan_deg_q16(step)});
    // rotate toward the x axis
    if (in_y > 0) begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + a;
    end else begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (adv) begin
      out_ctl <= in_ctl;
    end
    if (adv) begin
      out_val <= in_val;
      out_x   <= x_next;
      out_y   <= y_next;
      out_z   <= z_next;
    end
  end

endmodule

// ===== hdl/lsf_out.sv =====
// Output side of the slope filter: angle rounding, expansion of an item into
// its results, and the output register. Depends on lsf_pkg.
module lsf_out (
  input  logic                               clk,
  input  logic                               rst,
  input  lsf_pkg::lsf_ctl_t                  tail_ctl,
  input  logic [lsf_pkg::DATA_W-1:0]         tail_val,
  input  logic signed [lsf_pkg::ANGLE_W-1:0] tail_z,
  output logic                               adv,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lsf_pkg::DATA_W-1:0]         m_tdata,
  output logic [0:0]                         m_tuser,
  output logic                               m_tlast
);
  import lsf_pkg::*;

  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic              out_missing;
  logic              out_last;
  logic              phase;
  logic              phase_next;

  logic              out_load;
  logic              emit;
  logic [DATA_W-1:0] emit_val;
  logic              emit_missing;
  logic              emit_last;
  logic [DATA_W-1:0] pair_val;

  // angle: clamp negative to zero, round to 8 fraction bits, clamp to 90 deg
  always_comb begin
    logic [23:0]       zc;
    logic [ANGLE_W-1:0] zr;
    logic [16:0]       r;
    logic [15:0]       m;
    logic [DATA_W-1:0] m32;
    logic [DATA_W-1:0] angle_val;
    zc  = tail_z[ANGLE_W-1] ? '0 : tail_z[23:0];
    zr  = {1'b0, zc} + 25'd128;
    r   = zr[24:8];
    m   = (r > {1'b0, ANGLE_Q8_MAX}) ? ANGLE_Q8_MAX : r[15:0];
    if (tail_ctl.zero_p) m = '0;
    m32 = {16'd0, m};
    angle_val = tail_ctl.neg ? (~m32 + 32'd1) : m32;
    if (!tail_ctl.ok) begin
      pair_val = '0;
    end else if (tail_ctl.use_angle) begin
      pair_val = angle_val;
    end else begin
      pair_val = tail_val;
    end
  end

  // paired result first, then the row-end result; release the item after its last one
  always_comb begin
    out_load     = !out_valid || m_tready;
    emit         = 1'b0;
    emit_val     = '0;
    emit_missing = 1'b1;
    emit_last    = 1'b1;
    adv          = 1'b1;
    phase_next   = phase;
    if (tail_ctl.valid) begin
      if (tail_ctl.pair && !phase) begin
        emit         = out_load;
        emit_val     = pair_val;
        emit_missing = !tail_ctl.ok;
        emit_last    = !tail_ctl.row_end;
        adv          = out_load && !tail_ctl.row_end;
        if (out_load && tail_ctl.row_end) phase_next = 1'b1;
      end else if (tail_ctl.row_end) begin
        emit = out_load;
        adv  = out_load;
      end
    end
    if (adv) phase_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (out_load) out_valid <= emit;
    end
    if (out_load && emit) begin
      out_value   <= emit_val;
      out_missing <= emit_missing;
      out_last    <= emit_last;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_value;
  assign m_tuser[0] = out_missing;
  assign m_tlast    = out_last;

endmodule

// ===== hdl/left_neighbour_slope_filter_core.sv =====
// Top level of the horizontal neighbour slope filter.
// Depends on lsf_pkg, lsf_front, lsf_cordic_stage, lsf_out and the assertion header.
//
// Usage:
//   Raster cells enter in row order on the s_ stream, one item per cell; s_tlast
//   marks the last cell of a row. Each cell is paired with its right neighbour:
//   the result for a cell leaves once the next cell of the row has been taken,
//   and the last cell of a row always yields a no-data result right after the
//   pending one. An item therefore causes zero, one or two results on m_.
//   Registers (method, inverse_cell_size) are written on the cfg_ channel,
//   which is always ready; write them only while no item is in flight.
//   Depth: the first result of an item shows on m_tvalid once the item has passed
//   27 registers (3 front stages, 23 CORDIC stages, output register); a second
//   result follows it through the output register.
//   Throughput: one item per cycle while the output register can take results; an item
//   with two results holds the pipeline while the output register emits both, which sets the rate on rows that end.
//   Reset clears the pending cell, the pipeline valid bits and the output
//   register, and restores method 0 and inverse_cell_size 1.0.
//   When the receiver stalls, results wait in the output register and the
//   whole pipeline keeps advancing; s_tready drops only once the last
//   pipeline stage holds an item that cannot move into the output register.
`include "left_neighbour_slope_filter_core_assert.svh"

module left_neighbour_slope_filter_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [lsf_pkg::DATA_W-1:0]           s_tdata,   // [31:0] sample
  input  logic [0:0]                           s_tuser,   // [0] sample_missing
  input  logic                                 s_tlast,   // row_end
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [lsf_pkg::DATA_W-1:0]           m_tdata,   // [31:0] result_value
  output logic [0:0]                           m_tuser,   // [0] result_missing
  output logic                                 m_tlast,   // last
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lsf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [lsf_pkg::DATA_W-1:0]           cfg_data
);
  import lsf_pkg::*;

  // configuration registers
  logic [1:0]        method;
  logic [DATA_W-1:0] inv_cell_size;

  // pending cell of the current row
  logic [DATA_W-1:0] previous_sample;
  logic              previous_missing;
  logic              have_previous;

  logic              adv;
  logic              accept;
  logic              method_valid;
  lsf_ctl_t          in_ctl;

  lsf_ctl_t                  c_ctl [CORDIC_STEPS+1];
  logic [DATA_W-1:0]         c_val [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] c_x  [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] c_y  [CORDIC_STEPS+1];
  logic signed [ANGLE_W-1:0]  c_z  [CORDIC_STEPS+1];

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      method        <= METHOD_DIFF;
      inv_cell_size <= INV_CELL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_METHOD:   method        <= cfg_data[1:0];
        CFG_INV_CELL: inv_cell_size <= cfg_data;
        default:      ;
      endcase
    end
  end

  // whole pipeline moves together; take an item whenever it moves
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  // hold the cell until its right neighbour arrives; drop it at row end
  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous    <= 1'b0;
      previous_sample  <= '0;
      previous_missing <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        have_previous    <= 1'b0;
        previous_sample  <= '0;
        previous_missing <= 1'b0;
      end else begin
        have_previous    <= 1'b1;
        previous_sample  <= s_tdata;
        previous_missing <= s_tuser[0];
      end
    end
  end

  // the unused method code turns every paired result into no-data
  assign method_valid = (method == METHOD_DIFF) || (method == METHOD_PERCENT) ||
                        (method == METHOD_ANGLE);

  always_comb begin
    in_ctl         = '0;
    in_ctl.valid   = accept;
    in_ctl.pair    = have_previous;
    in_ctl.ok      = have_previous && !previous_missing && !s_tuser[0] && method_valid;
    in_ctl.row_end = s_tlast;
  end

  lsf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_ctl        (in_ctl),
    .in_a          ($signed(previous_sample)),
    .in_b          ($signed(s_tdata)),
    .method        (method),
    .inv_cell_size (inv_cell_size),
    .out_ctl       (c_ctl[0]),
    .out_val       (c_val[0]),
    .out_x         (c_x[0]),
    .out_y         (c_y[0])
  );

  assign c_z[0] = '0;

  // one CORDIC iteration per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    lsf_cordic_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .step    (STEP_W'(i)),
      .in_ctl  (c_ctl[i]),
      .in_val  (c_val[i]),
      .in_x    (c_x[i]),
      .in_y    (c_y[i]),
      .in_z    (c_z[i]),
      .out_ctl (c_ctl[i+1]),
      .out_val (c_val[i+1]),
      .out_x   (c_x[i+1]),
      .out_y   (c_y[i+1]),
      .out_z   (c_z[i+1])
    );
  end

  lsf_out u_out (
    .clk      (clk),
    .rst      (rst),
    .tail_ctl (c_ctl[CORDIC_STEPS]),
    .tail_val (c_val[CORDIC_STEPS]),
    .tail_z   (c_z[CORDIC_STEPS]),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // a row end leaves no cell pending; any other item becomes the pending cell
  `LSF_ASSERT_NEXT(a_row_end_clears, clk, rst, s_tvalid && s_tready && s_tlast, !have_previous)
  `LSF_ASSERT_NEXT(a_cell_pends, clk, rst, s_tvalid && s_tready && !s_tlast, have_previous)
  // input stalls only while the last pipeline stage holds an item
  `LSF_ASSERT_IMPLIES(a_stall_from_tail, clk, rst, !s_tready, c_ctl[CORDIC_STEPS].valid)
  // no-data results carry a zero value
  `LSF_ASSERT_IMPLIES(a_missing_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for left_neighbour_slope_filter_core: difference, percent slope
// and slope angle of each cell against its right neighbour, checked item by item.
// Depends on lsf_pkg and the filter RTL only.
`timescale 1ns / 100ps

module testbench;
  import lsf_pkg::*;

  localparam logic [1:0] METHOD_UNUSED = 2'd3;  // no method behind this code: all no-data
  localparam int         ROTATIONS     = 23;    // CORDIC iterations for the angle
  localparam longint     DEG90_Q8      = 23040; // 90 degrees, 8 fraction bits
  localparam int         DRAIN_CYCLES  = 40;    // long enough to drain the pipeline
  localparam int         STALL_LIMIT   = 2000;  // cycles with no handshake before giving up
  localparam int         PHASE_CELLS   = 480;

  // One raster cell as it enters, one result as it leaves.
  typedef struct packed {
    logic [31:0] sample;
    logic        missing;
    logic        row_end;
  } cell_t;

  typedef struct packed {
    logic [31:0] value;
    logic        missing;
    logic        last;
  } result_t;

  // Directed table: a cell to send or a register to write; pinned rows carry the
  // first result typed in by hand instead of the predicted one.
  typedef enum logic {ROW_CELL, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_INDEX_W-1:0]   reg_index;
    logic [31:0]              word;
    logic                     missing;
    logic                     row_end;
    logic                     pinned;
    logic [31:0]              want_value;
    logic                     want_missing;
  } plan_row_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata   = '0;  // [31:0] sample
  logic [0:0]             s_tuser   = '0;  // [0] sample_missing
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [DATA_W-1:0]      m_tdata;         // [31:0] result_value
  logic [0:0]             m_tuser;         // [0] result_missing
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]      cfg_data  = '0;

  // Predictor state: register copies and the cell waiting for its right neighbour.
  logic [1:0]  cur_method   = METHOD_DIFF;
  logic [31:0] cur_inv_cell = INV_CELL_RESET;
  logic [31:0] pend_sample  = '0;
  logic        pend_missing = 1'b0;
  logic        pend_valid   = 1'b0;

  result_t owed_results [$];  // results the block still owes, oldest first
  int      mismatches      = 0;
  int      feed_idle_pct   = 0;
  int      drain_stall_pct = 0;
  int      quiet_cycles    = 0;

  // atan(2^-i) in degrees with 16 fraction bits
  longint arctan_deg_q16 [0:ROTATIONS-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  plan_row_t directed_plan [$];

  left_neighbour_slope_filter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Slope angle atan2(rise, 2^32) in degrees, Q.8, by vectoring CORDIC.
  function automatic longint cordic_deg_q8(input longint unsigned rise);
    longint unsigned yy, xx;
    longint cx, cy, nx, ny, z, r;
    yy = rise;
    xx = 64'h1_0000_0000;
    // scale both legs down together so the vector fits the datapath
    while (yy >= 64'h100_0000_0000) begin
      yy = yy >> 1;
      xx = xx >> 1;
    end
    cx = xx;
    cy = yy;
    z  = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        z  = z + arctan_deg_q16[i];
      end else begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        z  = z - arctan_deg_q16[i];
      end
      cx = nx;
      cy = ny;
    end
    if (z < 0) z = 0;
    r = (z + 128) >>> 8;
    if (r > DEG90_Q8) r = DEG90_Q8;
    return r;
  endfunction

  // Value for a cell and its right neighbour under the current registers;
  // returns 0 when the method yields no data.
  function automatic bit pair_slope(input logic [31:0] cell_here, input logic [31:0] cell_east,
                                    output logic [31:0] value);
    longint          d, m;
    bit              neg;
    longint unsigned mag, p, hi, lo, q;
    d   = longint'($signed(cell_here)) - longint'($signed(cell_east));
    neg = d < 0;
    mag = neg ? -d : d;
    p   = mag * {32'd0, cur_inv_cell};  // ratio * 2^32
    value = '0;
    case (cur_method)
      METHOD_DIFF: begin
        value = clip32(d);
        return 1'b1;
      end
      METHOD_PERCENT: begin
        hi = p >> 24;
        lo = p & 64'hFF_FFFF;
        q  = 100 * hi + ((100 * lo + 64'h80_0000) >> 24);
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        m = q;
        value = clip32(neg ? -m : m);
        return 1'b1;
      end
      METHOD_ANGLE: begin
        m = (p == 0) ? 0 : cordic_deg_q8(p);
        m = neg ? -m : m;
        value = m[31:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Advance the predictor by one cell; returns how many results it causes.
  function automatic int predict_slopes(input cell_t c, output result_t first,
                                        output result_t second);
    int          n;
    bit          ok;
    logic [31:0] v;
    n      = 0;
    first  = '0;
    second = '0;
    if (pend_valid) begin
      ok = 1'b0;
      v  = '0;
      if (!pend_missing && !c.missing) ok = pair_slope(pend_sample, c.sample, v);
      if (!ok) v = '0;
      first = '{value: v, missing: !ok, last: !c.row_end};
      n = 1;
    end
    if (c.row_end) begin
      // the closing cell has no neighbour: always a trailing no-data result
      if (n == 0) first = '{value: '0, missing: 1'b1, last: 1'b1};
      else second = '{value: '0, missing: 1'b1, last: 1'b1};
      n = n + 1;
      pend_valid   = 1'b0;
      pend_sample  = '0;
      pend_missing = 1'b0;
    end else begin
      pend_valid   = 1'b1;
      pend_sample  = c.sample;
      pend_missing = c.missing;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------

  function automatic plan_row_t cell_row(input logic [31:0] w, input logic miss, input logic eol);
    return '{kind: ROW_CELL, reg_index: '0, word: w, missing: miss, row_end: eol,
             pinned: 1'b0, want_value: '0, want_missing: 1'b0};
  endfunction

  function automatic plan_row_t pinned_row(input logic [31:0] w, input logic miss,
                                           input logic eol, input logic [31:0] wv,
                                           input logic wm);
    return '{kind: ROW_CELL, reg_index: '0, word: w, missing: miss, row_end: eol,
             pinned: 1'b1, want_value: wv, want_missing: wm};
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [31:0] w);
    return '{kind: ROW_WRITE, reg_index: idx, word: w, missing: 1'b0, row_end: 1'b0,
             pinned: 1'b0, want_value: '0, want_missing: 1'b0};
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one cell, idling first at random; predict its results once taken.
  // A pinned row replaces the first predicted result by the typed-in one.
  task automatic send_cell(input cell_t c, input bit pinned, input result_t pin);
    result_t first, second;
    int      n;
    while ($urandom_range(99) < feed_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c.sample;
    s_tuser  <= c.missing;
    s_tlast  <= c.row_end;
    do @(posedge clk); while (!s_tready);
    n = predict_slopes(c, first, second);
    if (pinned) begin
      first.value   = pin.value;
      first.missing = pin.missing;
    end
    if (n > 0) owed_results.push_back(first);
    if (n > 1) owed_results.push_back(second);
  endtask

  // Hold off new cells until every owed result is in, then let the pipeline
  // drain cells that cause no result (first cell of a row).
  task automatic settle;
    s_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Raise a register write and hold it until taken; the caller drops cfg_valid.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] w);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_METHOD) cur_method = w[1:0];
    else cur_inv_cell = w;
  endtask

  // Pick a fresh method and cell size, the extremes among them.
  task automatic retune;
    logic [1:0]  method_code;
    logic [31:0] inv_word;
    int          pick;
    pick = $urandom_range(0, 9);
    method_code = (pick < 3) ? METHOD_DIFF :
                  (pick < 6) ? METHOD_PERCENT :
                  (pick < 9) ? METHOD_ANGLE : METHOD_UNUSED;
    case ($urandom_range(0, 9))
      0:       inv_word = 32'hFFFF_FFFF;
      1:       inv_word = 32'h0000_0001;
      2:       inv_word = 32'h0000_0000;
      3:       inv_word = INV_CELL_RESET;
      4, 5, 6: inv_word = $urandom_range(32'h0010_0000, 32'h1000_0000);  // cell 1/16 .. 16
      default: inv_word = $urandom();
    endcase
    settle();
    write_reg(CFG_METHOD, {30'd0, method_code});
    write_reg(CFG_INV_CELL, inv_word);
    cfg_valid <= 1'b0;
  endtask

  // Random rows: mostly smooth terrain as a random walk, some wild and extreme
  // elevations, a few empty cells; registers change now and then, mid-row too.
  task automatic random_phase(input int cells, input int feed_pct, input int drain_pct);
    cell_t       c;
    int          row_left, since_cfg, kind;
    logic [31:0] elev;
    feed_idle_pct   = feed_pct;
    drain_stall_pct = drain_pct;
    row_left  = 0;
    since_cfg = 0;
    elev      = $urandom();
    retune();
    for (int k = 0; k < cells; k++) begin
      if (since_cfg >= 100 && $urandom_range(0, 49) == 0) begin
        retune();
        since_cfg = 0;
      end
      if (row_left == 0) begin
        case ($urandom_range(0, 9))
          0:       row_left = 1;
          1:       row_left = $urandom_range(30, 60);
          default: row_left = $urandom_range(2, 12);
        endcase
      end
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        elev = $urandom();
      end else if (kind == 1) begin
        case ($urandom_range(0, 3))
          0:       elev = 32'h7FFF_FFFF;
          1:       elev = 32'h8000_0000;
          2:       elev = 32'h0000_0000;
          default: elev = 32'hFFFF_FFFF;
        endcase
      end else begin
        elev = elev + ($signed($urandom()) >>> $urandom_range(6, 31));
      end
      c.sample  = elev;
      c.missing = ($urandom_range(0, 9) == 0);
      c.row_end = (row_left == 1);
      row_left  = row_left - 1;
      send_cell(c, 1'b0, '0);
      since_cfg = since_cfg + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (owed_results.size() == 0) begin
        $error("result with none owed: value %h missing %0d last %0d",
               m_tdata, m_tuser[0], m_tlast);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        if (m_tdata !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, m_tdata);
          mismatches++;
        end
        if (m_tuser[0] !== want.missing) begin
          $error("result_missing: expected %0d, got %0d", want.missing, m_tuser[0]);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          mismatches++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= drain_stall_pct);
  end

  // Give up once nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results owed",
               quiet_cycles, owed_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    plan_row_t row;
    cell_t     c;
    result_t   pin;

    directed_plan = '{
      // reset registers: plain difference, cell size 1
      cell_row  (32'h0000_0100, 1'b0, 1'b0),                       // opens a row, nothing out
      pinned_row(32'h0000_0300, 1'b0, 1'b0, 32'hFFFF_FE00, 1'b0),  // 1.0 - 3.0
      cell_row  (32'h7FFF_FFFF, 1'b0, 1'b0),
      pinned_row(32'h8000_0000, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b0),  // max - min clips high
      pinned_row(32'h7FFF_FFFF, 1'b0, 1'b0, 32'h8000_0000, 1'b0),  // min - max clips low
      pinned_row(32'h1234_5678, 1'b1, 1'b0, 32'h0000_0000, 1'b1),  // right cell empty
      pinned_row(32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b1),  // left cell empty
      pinned_row(32'hFFFF_FF00, 1'b0, 1'b1, 32'h0000_0100, 1'b0),  // row end: pair, then no-data
      pinned_row(32'h5555_5555, 1'b0, 1'b1, 32'h0000_0000, 1'b1),  // one-cell row
      pinned_row(32'hAAAA_AAAA, 1'b1, 1'b1, 32'h0000_0000, 1'b1),
      write_row (CFG_METHOD, 32'(METHOD_PERCENT)),
      cell_row  (32'h0000_0A00, 1'b0, 1'b0),
      pinned_row(32'h0000_0000, 1'b0, 1'b0, 32'd256000, 1'b0),     // 10 over 1: 1000 percent
      pinned_row(32'h7FFF_FFFF, 1'b0, 1'b1, 32'h8000_0000, 1'b0),  // steep drop saturates
      write_row (CFG_INV_CELL, 32'hFFFF_FFFF),
      cell_row  (32'h8000_0000, 1'b0, 1'b0),
      pinned_row(32'h7FFF_FFFF, 1'b0, 1'b1, 32'h8000_0000, 1'b0),
      write_row (CFG_METHOD, 32'(METHOD_ANGLE)),
      cell_row  (32'h7FFF_FFFF, 1'b0, 1'b0),
      cell_row  (32'h8000_0000, 1'b0, 1'b0),                       // near vertical
      pinned_row(32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0),  // flat: zero degrees
      write_row (CFG_INV_CELL, 32'h0000_0001),
      cell_row  (32'h0000_0100, 1'b0, 1'b0),
      cell_row  (32'h0000_0000, 1'b0, 1'b1),                       // huge cell: tiny angle
      write_row (CFG_INV_CELL, 32'h0000_0000),
      cell_row  (32'h1000_0000, 1'b0, 1'b0),
      pinned_row(32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0),  // zero reciprocal
      write_row (CFG_METHOD, 32'(METHOD_UNUSED)),
      cell_row  (32'h0000_0100, 1'b0, 1'b0),
      pinned_row(32'h0000_0200, 1'b0, 1'b1, 32'h0000_0000, 1'b1),  // unused code: no data
      write_row (CFG_METHOD, 32'(METHOD_PERCENT)),
      cell_row  (32'h0000_0100, 1'b0, 1'b0),
      pinned_row(32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0)   // zero reciprocal
    };

    // hold reset first, then release it for good
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    feed_idle_pct   = 30;
    drain_stall_pct = 45;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.reg_index, row.word);
        cfg_valid <= 1'b0;
      end else begin
        c   = '{sample: row.word, missing: row.missing, row_end: row.row_end};
        pin = '{value: row.want_value, missing: row.want_missing, last: 1'b0};
        send_cell(c, row.pinned, pin);
      end
    end

    // sender idles less than the receiver stalls, then the reverse, then full rate
    random_phase(PHASE_CELLS, 30, 45);
    random_phase(PHASE_CELLS, 45, 30);
    random_phase(PHASE_CELLS, 0, 0);

    // drain everything owed and give stray results time to show up
    settle();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== left_neighbour_slope_filter_core.f =====
+incdir+hdl
hdl/lsf_pkg.sv
hdl/lsf_front.sv
hdl/lsf_cordic_stage.sv
hdl/lsf_out.sv
hdl/left_neighbour_slope_filter_core.sv
sim/testbench.sv
